@@ rtl/core/mmm_pkg.sv @@
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared types, widths and helper functions of the modulation matrix mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mmm_pkg;

   // Field widths.
   localparam int LEVEL_W     = 16;   // source level, signed Q1.15
   localparam int GAIN_W      = 16;   // slot intensity, signed Q1.15
   localparam int PROD_W      = 32;   // level times intensity
   localparam int FRAC_W      = 15;   // fraction bits dropped after the product
   localparam int TERM_W      = 17;   // one routed term after the shift
   localparam int SUM_W       = 19;   // destination sum, signed Q4.15
   localparam int CODE_W      = 4;    // source and destination codes
   localparam int SLOT_W      = 24;   // packed slot setting
   localparam int CSR_INDEX_W = 8;    // register index on the settings port

   localparam int NUM_SRC     = 8;
   localparam int NUM_DST     = 8;
   localparam int PIPE_DEPTH  = 4;

   // Intensity limits.
   localparam logic signed [GAIN_W-1:0] GAIN_MAX  = 16'sd32767;
   localparam logic signed [GAIN_W-1:0] GAIN_SKIP = 16'sd3;

   // Source codes.
   localparam logic [CODE_W-1:0] SRC_EG1       = 4'd0;
   localparam logic [CODE_W-1:0] SRC_EG2       = 4'd1;
   localparam logic [CODE_W-1:0] SRC_LFO1      = 4'd2;
   localparam logic [CODE_W-1:0] SRC_LFO2      = 4'd3;
   localparam logic [CODE_W-1:0] SRC_VELOCITY  = 4'd4;
   localparam logic [CODE_W-1:0] SRC_KEY_TRACK = 4'd5;
   localparam logic [CODE_W-1:0] SRC_BEND      = 4'd6;
   localparam logic [CODE_W-1:0] SRC_MOD_WHEEL = 4'd7;

   // Destination codes.
   localparam logic [CODE_W-1:0] DST_PITCH      = 4'd0;
   localparam logic [CODE_W-1:0] DST_OSC2_PITCH = 4'd1;
   localparam logic [CODE_W-1:0] DST_OSC1_CTRL  = 4'd2;
   localparam logic [CODE_W-1:0] DST_NOISE      = 4'd3;
   localparam logic [CODE_W-1:0] DST_CUTOFF     = 4'd4;
   localparam logic [CODE_W-1:0] DST_AMP        = 4'd5;
   localparam logic [CODE_W-1:0] DST_PAN        = 4'd6;
   localparam logic [CODE_W-1:0] DST_LFO2_RATE  = 4'd7;

   // One routing slot as held after a settings write.
   typedef struct packed {
      logic [CODE_W-1:0]        src;
      logic [CODE_W-1:0]        dst;
      logic signed [GAIN_W-1:0] gain;
   } slot_type;

   // Clamps the intensity to plus or minus one and folds tiny intensities
   // to zero, so that a skipped slot simply contributes a zero product.
   function automatic logic signed [GAIN_W-1:0] effective_gain(
      input logic signed [GAIN_W-1:0] raw
   );
      logic signed [GAIN_W-1:0] g;
      g = (raw < -GAIN_MAX) ? -GAIN_MAX : raw;
      if ((g <= GAIN_SKIP) && (g >= -GAIN_SKIP)) begin
         g = '0;
      end
      return g;
   endfunction

   // Unpacks a settings word into a slot.
   function automatic slot_type decode_slot(input logic [SLOT_W-1:0] word);
      slot_type s;
      s.src  = word[CODE_W-1:0];
      s.dst  = word[2*CODE_W-1:CODE_W];
      s.gain = effective_gain(word[SLOT_W-1:2*CODE_W]);
      return s;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/mmm_if.sv @@
// ----------------------------------------------------------------------------
// mmm_if
// Channel interfaces of the modulation matrix mixer: source vector input,
// destination sum output and slot settings writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mmm_pkg::LEVEL_W-1:0]  eg1_level;
   logic signed [mmm_pkg::LEVEL_W-1:0]  eg2_level;
   logic signed [mmm_pkg::LEVEL_W-1:0]  lfo1_level;
   logic signed [mmm_pkg::LEVEL_W-1:0]  lfo2_level;
   logic signed [mmm_pkg::LEVEL_W-1:0]  velocity_level;
   logic signed [mmm_pkg::LEVEL_W-1:0]  key_track_level;
   logic signed [mmm_pkg::LEVEL_W-1:0]  pitch_bend_level;
   logic signed [mmm_pkg::LEVEL_W-1:0]  mod_wheel_level;

   modport source (
      output valid, eg1_level, eg2_level, lfo1_level, lfo2_level,
             velocity_level, key_track_level, pitch_bend_level, mod_wheel_level,
      input  ready
   );
   modport sink (
      input  valid, eg1_level, eg2_level, lfo1_level, lfo2_level,
             velocity_level, key_track_level, pitch_bend_level, mod_wheel_level,
      output ready
   );
endinterface

interface mmm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mmm_pkg::SUM_W-1:0]  pitch_sum;
   logic signed [mmm_pkg::SUM_W-1:0]  osc2_pitch_sum;
   logic signed [mmm_pkg::SUM_W-1:0]  osc1_control_sum;
   logic signed [mmm_pkg::SUM_W-1:0]  noise_level_sum;
   logic signed [mmm_pkg::SUM_W-1:0]  cutoff_sum;
   logic signed [mmm_pkg::SUM_W-1:0]  amp_sum;
   logic signed [mmm_pkg::SUM_W-1:0]  pan_sum;
   logic signed [mmm_pkg::SUM_W-1:0]  lfo2_rate_sum;

   modport source (
      output valid, pitch_sum, osc2_pitch_sum, osc1_control_sum, noise_level_sum,
             cutoff_sum, amp_sum, pan_sum, lfo2_rate_sum,
      input  ready
   );
   modport sink (
      input  valid, pitch_sum, osc2_pitch_sum, osc1_control_sum, noise_level_sum,
             cutoff_sum, amp_sum, pan_sum, lfo2_rate_sum,
      output ready
   );
endinterface

interface mmm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mmm_pkg::CSR_INDEX_W-1:0]    index;
   logic [mmm_pkg::SLOT_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/modulation_matrix_mix.sv @@
// ----------------------------------------------------------------------------
// modulation_matrix_mix
// Routes eight modulation source levels through SLOT_COUNT weighted slots
// into eight destination sums, one vector per clock while the output is taken.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transaction carries
//  --------  ---------  ------------------------------------------------------
//  req_bus   in         eight signed Q1.15 source levels
//  rsp_bus   out        eight signed Q4.15 destination sums
//  csr_bus   in         slot index and 24-bit slot setting
//
//  Four register stages: source select, multiply, shift and half sums, final
//  sum. The multiplier stage sets the clock; one vector enters every cycle
//  while the output is taken.
//  Reset is synchronous and clears all valid bits and all slot settings.
//  Each stage holds its contents while the stage after it is full and stalled,
//  and takes new data whenever it is empty, so bubbles are squeezed out.
//
`default_nettype none

module modulation_matrix_mix #(
   parameter int SLOT_COUNT = 8
) (
   input  wire       clock,
   input  wire       reset,
   mmm_req_if.sink   req_bus,
   mmm_rsp_if.source rsp_bus,
   mmm_csr_if.sink   csr_bus
);

   // Slots below SPLIT feed the first half sum, the rest the second.
   localparam int SPLIT = (SLOT_COUNT + 1) / 2;

   // ---------------------------------------------------------------------
   // Slot settings. Writes to an index at or above SLOT_COUNT are dropped,
   // since those slots never reach the sums.
   // ---------------------------------------------------------------------
   mmm_pkg::slot_type slot_ff [SLOT_COUNT];

   assign csr_bus.ready = 1'b1;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
      always_ff @(posedge clock) begin
         if (reset) begin
            slot_ff[i] <= '0;
         end else if (csr_bus.valid && csr_bus.ready &&
                      (csr_bus.index == mmm_pkg::CSR_INDEX_W'(i))) begin
            slot_ff[i] <= mmm_pkg::decode_slot(csr_bus.data);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stall control. A stage advances when it is empty or the next one does.
   // ---------------------------------------------------------------------
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4 = !valid4_ff || rsp_bus.ready;
   assign adv3 = !valid3_ff || adv4;
   assign adv2 = !valid2_ff || adv3;
   assign adv1 = !valid1_ff || adv2;

   assign req_bus.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (adv1) valid1_ff <= req_bus.valid;
         if (adv2) valid2_ff <= valid1_ff;
         if (adv3) valid3_ff <= valid2_ff;
         if (adv4) valid4_ff <= valid3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: pick each slot's source level. Source codes above the last
   // input give a level of zero.
   // ---------------------------------------------------------------------
   logic signed [mmm_pkg::LEVEL_W-1:0] levels [mmm_pkg::NUM_SRC];

   always_comb begin
      levels[mmm_pkg::SRC_EG1[mmm_pkg::CODE_W-2:0]]       = req_bus.eg1_level;
      levels[mmm_pkg::SRC_EG2[mmm_pkg::CODE_W-2:0]]       = req_bus.eg2_level;
      levels[mmm_pkg::SRC_LFO1[mmm_pkg::CODE_W-2:0]]      = req_bus.lfo1_level;
      levels[mmm_pkg::SRC_LFO2[mmm_pkg::CODE_W-2:0]]      = req_bus.lfo2_level;
      levels[mmm_pkg::SRC_VELOCITY[mmm_pkg::CODE_W-2:0]]  = req_bus.velocity_level;
      levels[mmm_pkg::SRC_KEY_TRACK[mmm_pkg::CODE_W-2:0]] = req_bus.key_track_level;
      levels[mmm_pkg::SRC_BEND[mmm_pkg::CODE_W-2:0]]      = req_bus.pitch_bend_level;
      levels[mmm_pkg::SRC_MOD_WHEEL[mmm_pkg::CODE_W-2:0]] = req_bus.mod_wheel_level;
   end

   logic signed [mmm_pkg::LEVEL_W-1:0] level1_ff [SLOT_COUNT];
   logic signed [mmm_pkg::GAIN_W-1:0]  gain1_ff  [SLOT_COUNT];
   logic [mmm_pkg::CODE_W-1:0]         dst1_ff   [SLOT_COUNT];

   // Stage 2: one 16 by 16 product per slot.
   logic signed [mmm_pkg::PROD_W-1:0]  prod2_ff  [SLOT_COUNT];
   logic [mmm_pkg::CODE_W-1:0]         dst2_ff   [SLOT_COUNT];

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_lane
      always_ff @(posedge clock) begin
         if (adv1) begin
            level1_ff[i] <= slot_ff[i].src[mmm_pkg::CODE_W-1] ? '0 :
                            levels[slot_ff[i].src[mmm_pkg::CODE_W-2:0]];
            gain1_ff[i]  <= slot_ff[i].gain;
            dst1_ff[i]   <= slot_ff[i].dst;
         end
         if (adv2) begin
            prod2_ff[i] <= mmm_pkg::PROD_W'(level1_ff[i]) *
                           mmm_pkg::PROD_W'(gain1_ff[i]);
            dst2_ff[i]  <= dst1_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: arithmetic shift (floor) of each product, then two half sums
   // per destination. Destination codes above the last output match nothing
   // and so drop their term.
   // ---------------------------------------------------------------------
   logic signed [mmm_pkg::TERM_W-1:0] terms      [SLOT_COUNT];
   logic signed [mmm_pkg::SUM_W-1:0]  part_a_in  [mmm_pkg::NUM_DST];
   logic signed [mmm_pkg::SUM_W-1:0]  part_b_in  [mmm_pkg::NUM_DST];
   logic signed [mmm_pkg::SUM_W-1:0]  part_a_ff  [mmm_pkg::NUM_DST];
   logic signed [mmm_pkg::SUM_W-1:0]  part_b_ff  [mmm_pkg::NUM_DST];
   logic signed [mmm_pkg::SUM_W-1:0]  sum4_ff    [mmm_pkg::NUM_DST];

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         terms[i] = mmm_pkg::TERM_W'(prod2_ff[i] >>> mmm_pkg::FRAC_W);
      end
      for (int d = 0; d < mmm_pkg::NUM_DST; d++) begin
         part_a_in[d] = '0;
         part_b_in[d] = '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (dst2_ff[i] == mmm_pkg::CODE_W'(d)) begin
               if (i < SPLIT) begin
                  part_a_in[d] = part_a_in[d] + mmm_pkg::SUM_W'(terms[i]);
               end else begin
                  part_b_in[d] = part_b_in[d] + mmm_pkg::SUM_W'(terms[i]);
               end
            end
         end
      end
   end

   // Stage 4: final sum. Eight terms of at most one in magnitude always fit.
   always_ff @(posedge clock) begin
      for (int d = 0; d < mmm_pkg::NUM_DST; d++) begin
         if (adv3) begin
            part_a_ff[d] <= part_a_in[d];
            part_b_ff[d] <= part_b_in[d];
         end
         if (adv4) begin
            sum4_ff[d] <= part_a_ff[d] + part_b_ff[d];
         end
      end
   end

   assign rsp_bus.valid            = valid4_ff;
   assign rsp_bus.pitch_sum        = sum4_ff[mmm_pkg::DST_PITCH[mmm_pkg::CODE_W-2:0]];
   assign rsp_bus.osc2_pitch_sum   = sum4_ff[mmm_pkg::DST_OSC2_PITCH[mmm_pkg::CODE_W-2:0]];
   assign rsp_bus.osc1_control_sum = sum4_ff[mmm_pkg::DST_OSC1_CTRL[mmm_pkg::CODE_W-2:0]];
   assign rsp_bus.noise_level_sum  = sum4_ff[mmm_pkg::DST_NOISE[mmm_pkg::CODE_W-2:0]];
   assign rsp_bus.cutoff_sum       = sum4_ff[mmm_pkg::DST_CUTOFF[mmm_pkg::CODE_W-2:0]];
   assign rsp_bus.amp_sum          = sum4_ff[mmm_pkg::DST_AMP[mmm_pkg::CODE_W-2:0]];
   assign rsp_bus.pan_sum          = sum4_ff[mmm_pkg::DST_PAN[mmm_pkg::CODE_W-2:0]];
   assign rsp_bus.lfo2_rate_sum    = sum4_ff[mmm_pkg::DST_LFO2_RATE[mmm_pkg::CODE_W-2:0]];

endmodule

`default_nettype wire

@@ rtl/core/mmm_checker.sv @@
// ----------------------------------------------------------------------------
// mmm_checker
// Port-level assertions for the modulation matrix mixer, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module mmm_checker (
   input wire                                    clock,
   input wire                                    reset,
   input wire                                    req_valid,
   input wire                                    req_ready,
   input wire                                    rsp_valid,
   input wire                                    rsp_ready,
   input wire [mmm_pkg::NUM_DST*mmm_pkg::SUM_W-1:0] rsp_data
);

   localparam int CNT_W = $clog2(mmm_pkg::PIPE_DEPTH + 1);

   logic             acc_in, acc_out;
   logic [CNT_W-1:0] count_ff, count_in;

   assign acc_in   = req_valid && req_ready;
   assign acc_out  = rsp_valid && rsp_ready;
   assign count_in = count_ff + CNT_W'(acc_in) - CNT_W'(acc_out);

   // Transactions in flight between the two channels.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(mmm_pkg::PIPE_DEPTH))
      else $error("more transactions in flight than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != '0))
      else $error("result presented with nothing in flight");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == CNT_W'(mmm_pkg::PIPE_DEPTH)) && !rsp_ready) |-> !req_ready)
      else $error("input taken while pipeline full and stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

endmodule

bind modulation_matrix_mix mmm_checker u_mmm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  ({rsp_bus.pitch_sum, rsp_bus.osc2_pitch_sum, rsp_bus.osc1_control_sum,
                rsp_bus.noise_level_sum, rsp_bus.cutoff_sum, rsp_bus.amp_sum,
                rsp_bus.pan_sum, rsp_bus.lfo2_rate_sum})
);

`default_nettype wire

@@ tb/sv/mmm_mix_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mmm_mix_checker
// Watches the three channels of the modulation matrix mixer, keeps its own
// copy of the slot routing, computes the destination sums of every accepted
// source vector and compares them with the results, field by field.
// ----------------------------------------------------------------------------

module mmm_mix_checker #(
   parameter int SLOT_COUNT = 8
) (
   input  wire  clock,
   input  wire  reset,
   mmm_req_if   req_bus,
   mmm_rsp_if   rsp_bus,
   mmm_csr_if   csr_bus,
   output int   mismatch_count,
   output int   pending_count
);
   import mmm_pkg::*;

   localparam int SLOT_REGS    = 8;
   localparam int REPORT_LIMIT = 10;

   typedef logic [NUM_SRC-1:0][LEVEL_W-1:0] level_vec_t;
   typedef logic [NUM_DST-1:0][SUM_W-1:0]   sum_vec_t;

   slot_type routing [SLOT_REGS];
   sum_vec_t expected_sums [$];
   int       fail_tally = 0;
   string    dst_names [NUM_DST] = '{"pitch_sum", "osc2_pitch_sum", "osc1_control_sum",
                                     "noise_level_sum", "cutoff_sum", "amp_sum",
                                     "pan_sum", "lfo2_rate_sum"};

   // A written setting keeps its codes; only the most negative intensity
   // changes, since minus one is held as -32767.
   function automatic slot_type unpack_setting(input logic [SLOT_W-1:0] word);
      slot_type                 s;
      logic signed [GAIN_W-1:0] raw;
      raw    = word[SLOT_W-1:2*CODE_W];
      s.src  = word[CODE_W-1:0];
      s.dst  = word[2*CODE_W-1:CODE_W];
      s.gain = (raw < -GAIN_MAX) ? -GAIN_MAX : raw;
      return s;
   endfunction

   function automatic sum_vec_t mix_levels(input level_vec_t levels);
      int       acc [NUM_DST];
      int       lvl;
      int       g;
      int       i;
      int       d;
      sum_vec_t r;
      for (d = 0; d < NUM_DST; d++) acc[d] = 0;
      for (i = 0; i < SLOT_COUNT && i < SLOT_REGS; i++) begin
         g = $signed(routing[i].gain);
         if (g <= int'(GAIN_SKIP) && g >= -int'(GAIN_SKIP)) continue;
         lvl = 0;
         if (routing[i].src < NUM_SRC) lvl = $signed(levels[routing[i].src]);
         // The arithmetic shift of a signed product rounds toward minus infinity.
         if (routing[i].dst < NUM_DST) acc[routing[i].dst] += (lvl * g) >>> FRAC_W;
      end
      for (d = 0; d < NUM_DST; d++) r[d] = acc[d][SUM_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      sum_vec_t got;
      sum_vec_t want;
      int       d;
      if (reset) begin
         for (d = 0; d < SLOT_REGS; d++) routing[d] = '0;
         expected_sums.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_sums.push_back(mix_levels({req_bus.mod_wheel_level,
               req_bus.pitch_bend_level, req_bus.key_track_level, req_bus.velocity_level,
               req_bus.lfo2_level, req_bus.lfo1_level, req_bus.eg2_level,
               req_bus.eg1_level}));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.lfo2_rate_sum, rsp_bus.pan_sum, rsp_bus.amp_sum,
                   rsp_bus.cutoff_sum, rsp_bus.noise_level_sum, rsp_bus.osc1_control_sum,
                   rsp_bus.osc2_pitch_sum, rsp_bus.pitch_sum};
            if (expected_sums.size() == 0) begin
               fail_tally++;
               if (fail_tally <= REPORT_LIMIT)
                  $display("%0t: result transaction with nothing expected", $realtime);
            end else begin
               want = expected_sums.pop_front();
               for (d = 0; d < NUM_DST; d++) begin
                  if (got[d] !== want[d]) begin
                     fail_tally++;
                     if (fail_tally <= REPORT_LIMIT)
                        $display("%0t: %s expected %0d, got %0d", $realtime, dst_names[d],
                                 $signed(want[d]), $signed(got[d]));
                  end
               end
            end
         end
         // The bench must write settings only while no vector is in flight; the checker does not enforce it.
         if (csr_bus.valid && csr_bus.ready && csr_bus.index < SLOT_REGS)
            routing[csr_bus.index] = unpack_setting(csr_bus.data);
      end
      mismatch_count <= fail_tally;
      pending_count  <= expected_sums.size();
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the modulation matrix mixer. Writes slot routings while the
// block is idle, then streams source vectors through it under random idling
// on both channels; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------

module tb;
   import mmm_pkg::*;

   localparam int SLOT_COUNT     = 8;
   localparam int SLOT_REGS      = 8;
   localparam int RESET_CYCLES   = 7;
   localparam int RANDOM_PHASES  = 13;
   localparam int PHASE_ITEMS    = 150;
   localparam int QUIET_PHASES   = 2;    // closing phases run without idling
   localparam int HOLD_PHASE     = 3;    // phase in which the output is held off
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   // Codes 8 to 15 route nothing: the source reads as zero, the destination
   // drops the term.
   localparam logic [CODE_W-1:0]        CODE_UNUSED_LOW  = 4'd8;
   localparam logic [CODE_W-1:0]        CODE_UNUSED_HIGH = 4'd15;
   localparam logic [CSR_INDEX_W-1:0]   INDEX_LAST       = 8'hFF;
   localparam logic signed [GAIN_W-1:0] GAIN_MOST_NEG    = 16'sh8000;

   typedef logic [NUM_SRC-1:0][LEVEL_W-1:0] level_vec_t;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   idle_cycles = 0;

   // Idling controls shared by the sender and the receiver. An odds value N
   // starts a burst for about one in N sent vectors or receiver steps; zero means no idling at all.
   int   req_gap_odds     = 0;
   int   rsp_stall_odds   = 0;
   bit   rsp_hold_request = 1'b0;

   mmm_req_if req_bus ();
   mmm_rsp_if rsp_bus ();
   mmm_csr_if csr_bus ();

   modulation_matrix_mix #(
      .SLOT_COUNT (SLOT_COUNT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   mmm_mix_checker #(
      .SLOT_COUNT (SLOT_COUNT)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------

   // One settings transaction. Valid drops for a cycle afterwards, so that two
   // writes in a row never lower and raise it in the same time step.
   task automatic write_slot(input logic [CSR_INDEX_W-1:0] reg_index,
                             input logic [SLOT_W-1:0] word);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data  <= word;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one source vector and returns at the edge where it was accepted.
   // Valid stays high so that the next vector can follow without a bubble;
   // a random gap lowers it first.
   task automatic send_levels(input level_vec_t levels);
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.eg1_level        <= levels[SRC_EG1];
      req_bus.eg2_level        <= levels[SRC_EG2];
      req_bus.lfo1_level       <= levels[SRC_LFO1];
      req_bus.lfo2_level       <= levels[SRC_LFO2];
      req_bus.velocity_level   <= levels[SRC_VELOCITY];
      req_bus.key_track_level  <= levels[SRC_KEY_TRACK];
      req_bus.pitch_bend_level <= levels[SRC_BEND];
      req_bus.mod_wheel_level  <= levels[SRC_MOD_WHEEL];
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Ends a burst of vectors and waits until every result has come back. The
   // extra edge lets the checker count the vector accepted at the last edge
   // before its outstanding count is read.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic send_uniform(input logic [LEVEL_W-1:0] level);
      send_levels({NUM_SRC{level}});
   endtask

   // Levels lean toward the extremes and toward values near zero, where the
   // rounding of negative products shows.
   function automatic level_vec_t random_levels();
      level_vec_t v;
      int         s;
      for (s = 0; s < NUM_SRC; s++) begin
         case ($urandom_range(0, 5))
            0:       v[s] = 16'h8000;
            1:       v[s] = 16'h7FFF;
            2:       v[s] = 16'($urandom_range(0, 8)) - 16'd4;
            default: v[s] = 16'($urandom);
         endcase
      end
      return v;
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(0, 7))
         0:       return GAIN_MOST_NEG;
         1:       return GAIN_MAX;
         2:       return -GAIN_MAX;
         3:       return 16'($urandom_range(0, 8)) - 16'd4;   // around the skip limit
         4:       return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] random_code();
      if ($urandom_range(0, 5) == 0)
         return CODE_W'($urandom_range(CODE_UNUSED_LOW, CODE_UNUSED_HIGH));
      return CODE_W'($urandom_range(0, NUM_SRC - 1));
   endfunction

   // --------------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request. During
   // the hold the sender keeps offering vectors, so the pipeline fills and the
   // block has to stall its input.
   // --------------------------------------------------------------------------
   initial begin : rsp_side
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Watchdog: counts cycles in which no channel moves a transaction.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin : main_sequence
      int               p;
      int               n;
      int               s;
      bit               quiet;
      logic [GAIN_W-1:0] gain;

      // Every input is known from time zero.
      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.eg1_level        <= '0;
      req_bus.eg2_level        <= '0;
      req_bus.lfo1_level       <= '0;
      req_bus.lfo2_level       <= '0;
      req_bus.velocity_level   <= '0;
      req_bus.key_track_level  <= '0;
      req_bus.pitch_bend_level <= '0;
      req_bus.mod_wheel_level  <= '0;
      csr_bus.valid            <= 1'b0;
      csr_bus.index            <= '0;
      csr_bus.data             <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // After reset every slot has zero intensity, so every sum is zero even
      // at full-scale levels.
      send_uniform(16'h7FFF);
      send_uniform(16'h8000);
      drain_results();

      // Straight routing at full scale: source n to destination n. Negative
      // levels check that the shift rounds toward minus infinity.
      for (s = 0; s < SLOT_REGS; s++)
         write_slot(CSR_INDEX_W'(s), {GAIN_MAX, CODE_W'(s), CODE_W'(s)});
      rsp_stall_odds = 3;
      send_uniform(16'h7FFF);
      send_uniform(16'h8000);
      send_uniform(16'hFFFF);
      send_levels({16'h1234, 16'h0000, 16'hC000, 16'h4000, 16'hFFFF, 16'h0001,
                   16'h7FFF, 16'h8000});
      drain_results();

      // Corner slots: a clamped minus one, intensities just inside and just
      // outside the skip limit, unused source codes, dropped destinations.
      write_slot(8'd0, {GAIN_MOST_NEG, DST_PITCH, SRC_EG1});
      write_slot(8'd1, {16'sd3, DST_PITCH, SRC_EG2});
      write_slot(8'd2, {-16'sd3, DST_PITCH, SRC_LFO1});
      write_slot(8'd3, {16'sd4, DST_AMP, SRC_LFO2});
      write_slot(8'd4, {GAIN_MAX, DST_CUTOFF, CODE_UNUSED_LOW});
      write_slot(8'd5, {-16'sd4, DST_PAN, CODE_UNUSED_HIGH});
      write_slot(8'd6, {GAIN_MAX, CODE_UNUSED_LOW, SRC_VELOCITY});
      write_slot(8'd7, {-GAIN_MAX, CODE_UNUSED_HIGH, SRC_MOD_WHEEL});
      // Writes past the last slot must leave every slot as it is; the data
      // would show up in the sums if the index were folded onto a slot.
      write_slot(8'd8, {GAIN_MAX, DST_LFO2_RATE, SRC_KEY_TRACK});
      write_slot(INDEX_LAST, {16'sh4000, DST_OSC2_PITCH, SRC_MOD_WHEEL});
      send_uniform(16'h7FFF);
      send_uniform(16'h8000);
      send_levels(random_levels());
      send_levels(random_levels());
      drain_results();

      // All eight slots pile onto one destination with a clamped minus one:
      // the sum reaches its largest magnitude in both directions.
      for (s = 0; s < SLOT_REGS; s++)
         write_slot(CSR_INDEX_W'(s), {GAIN_MOST_NEG, DST_PITCH, CODE_W'(s)});
      send_uniform(16'h8000);
      send_uniform(16'h7FFF);
      send_uniform(16'h0001);
      drain_results();

      // Random phases. The first two use the extreme intensities on every
      // slot; the rest draw whole routings at random.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         for (s = 0; s < SLOT_REGS; s++) begin
            if (p == 0)
               gain = GAIN_MAX;
            else if (p == 1)
               gain = GAIN_MOST_NEG;
            else
               gain = random_gain();
            write_slot(CSR_INDEX_W'(s), {gain, random_code(), random_code()});
         end
         if ($urandom_range(0, 1) == 1)
            write_slot(CSR_INDEX_W'($urandom_range(SLOT_REGS, INDEX_LAST)),
                       SLOT_W'($urandom));

         // Every third phase runs without gaps from the sender; the closing
         // phases run with no idling on either side.
         quiet          = (p >= RANDOM_PHASES - QUIET_PHASES);
         req_gap_odds   = (quiet || p % 3 == 2) ? 0 : $urandom_range(2, 10);
         rsp_stall_odds = (quiet || p % 4 == 1) ? 0 : $urandom_range(2, 12);
         if (p == HOLD_PHASE)
            rsp_hold_request = 1'b1;

         for (n = 0; n < PHASE_ITEMS; n++)
            send_levels(random_levels());
         drain_results();
      end

      // Let any stray result show up before the verdict.
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
